// ----- rtl/qrs_pkg.sv -----
// shared constants and types of the quadratic root solver
`timescale 1ns / 1ps

package qrs_pkg;

	// default word format, signed Q16.16
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	// tolerance register
	localparam int EPS_BITS = 16;
	localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;

	// root count codes
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;
	localparam logic [1:0] CNT_INF  = 2'd3;

	// how an equation is finished after classification
	typedef enum logic [2:0] {
		MD_FIXED, // count known, roots read zero
		MD_LIN,   // linear equation, one quotient root
		MD_SQRT,  // zero-b case, roots are +-sqrt(-c/a)
		MD_ZC,    // zero-c case, roots 0 and -b/a
		MD_GEN    // full discriminant path
	} mode_t;

endpackage

// ----- rtl/qrs_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module qrs_div #(
	parameter int NB = 64, // numerator and quotient bits, one stage each
	parameter int DB = 32, // divisor bits
	parameter int SB = 1   // side information carried with each item
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NB-1:0] num,
	input  logic [DB-1:0] den,
	input  logic [SB-1:0] side_in,
	output logic          out_valid,
	output logic [NB-1:0] quo,
	output logic [DB-1:0] rem,
	output logic [DB-1:0] den_out,
	output logic [SB-1:0] side_out
);

	// stage registers; the numerator word shifts out at the top while
	// quotient bits shift in at the bottom
	logic          v_s  [NB];
	logic [NB-1:0] n_s  [NB];
	logic [DB-1:0] r_s  [NB];
	logic [DB-1:0] d_s  [NB];
	logic [SB-1:0] sd_s [NB];

	for (genvar i = 0; i < NB; i++) begin : g_stage
		logic          v_in;
		logic [NB-1:0] n_in;
		logic [DB-1:0] r_in;
		logic [DB-1:0] d_in;
		logic [SB-1:0] sd_in;
		logic [DB:0]   trial;
		logic [DB:0]   diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign v_in  = in_valid;
			assign n_in  = num;
			assign r_in  = '0;
			assign d_in  = den;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = v_s[i-1];
			assign n_in  = n_s[i-1];
			assign r_in  = r_s[i-1];
			assign d_in  = d_s[i-1];
			assign sd_in = sd_s[i-1];
		end

		// bring down one numerator bit and try a subtract
		assign trial = {r_in, n_in[NB-1]};
		assign diff  = trial - {1'b0, d_in};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i]  <= {n_in[NB-2:0], ge};
				r_s[i]  <= ge ? diff[DB-1:0] : trial[DB-1:0];
				d_s[i]  <= d_in;
				sd_s[i] <= sd_in;
			end
		end
	end

	assign out_valid = v_s[NB-1];
	assign quo       = n_s[NB-1];
	assign rem       = r_s[NB-1];
	assign den_out   = d_s[NB-1];
	assign side_out  = sd_s[NB-1];

endmodule

// ----- rtl/quadratic_root_solver.sv -----
// top level of the pipelined real-root solver for a*x^2 + b*x + c = 0
`timescale 1ns / 1ps
// Usage
//   s_axis carries one equation per transfer: coef_a, coef_b, coef_c, signed
//   fixed point. m_axis returns one result per equation in the same order:
//   root_low and root_high in tdata, root_count and overflow in tuser.
//   cfg carries the epsilon tolerance; it is always ready and should only
//   be written while no equation is in flight.
// Throughput: one equation per cycle while m_axis_tready stays high.
// Pipeline: an equation (Q16.16 by default) passes capture, classification,
//   the products, the discriminant, the divider for the zero-b ratio, the
//   bit-pair square root (SR stages), root rounding, operand selection, the
//   rounding dividers for the roots (N1 stages), sign, and the output register.
// Stall: the whole pipeline holds while a result waits on m_axis_tready;
//   s_axis_tready drops only while the output register is full and stalled.
// Reset: arst_n clears every valid bit and sets epsilon to 1; no clearing
//   pass is needed.

module quadratic_root_solver
	import qrs_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// equation stream; tdata from bit 0: coef_a, coef_b, coef_c, zero fill
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  logic [((3*WORD_BITS+7)/8)*8-1:0]           s_axis_tdata,
	// result stream; tdata from bit 0: root_low, root_high, zero fill
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	output logic [((2*WORD_BITS+7)/8)*8-1:0]           m_axis_tdata,
	// tuser from bit 0: root_count (2 bits), overflow
	output logic [2:0]                                 m_axis_tuser,
	// epsilon write channel
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [EPS_BITS-1:0]                        cfg_data
);

	localparam int W      = WORD_BITS;
	localparam int F      = FRAC_BITS;
	localparam int PW     = 2 * W;             // product of two magnitudes
	localparam int DW     = 2 * W + 1;         // discriminant
	localparam int N0     = W + 2 * F;         // zero-b ratio numerator
	localparam int SX_RAW = (DW > N0) ? DW : N0;
	localparam int SXE    = SX_RAW + (SX_RAW % 2);
	localparam int SR     = SXE / 2;           // square root stages
	localparam int RW     = SR + 2;            // square root remainder
	localparam int NM     = ((W > SR + 1) ? W : SR + 1) + 1; // |-b +- s|
	localparam int NW     = NM + 1;
	localparam int N1     = NM + F;            // root divider numerator
	localparam int DB1    = W + 1;             // root divider divisor
	localparam int XW     = N1 + 2;            // signed root before clamp
	localparam int TDO    = ((2 * W + 7) / 8) * 8;

	localparam logic signed [XW-1:0] SMAX = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [XW-1:0] SMIN = ~SMAX;

	// side information through the front dividers and the square root
	typedef struct packed {
		mode_t         mode;
		logic [1:0]    cnt;
		logic          neg1;
		logic          a_neg;
		logic [W-1:0]  b;
		logic [W-1:0]  amag;
		logic [W-1:0]  bmag;
		logic [W-1:0]  cmag;
	} fr_t;

	typedef struct packed {
		fr_t           f;
		logic [DW-1:0] d;
	} d0_t;

	// side information through the root dividers
	typedef struct packed {
		mode_t         mode;
		logic [1:0]    cnt;
		logic          neg1;
		logic [SR:0]   s;
	} bk_t;

	// clamp to the word range, overflow flag on top
	function automatic logic [W:0] sat_w(input logic signed [XW-1:0] v);
		logic [W:0] r;
		if (v > SMAX) begin
			r = {1'b1, SMAX[W-1:0]};
		end else if (v < SMIN) begin
			r = {1'b1, SMIN[W-1:0]};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	logic en;
	logic [EPS_BITS-1:0] eps_q;

	// global advance: the output register is empty or being drained
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// epsilon register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			eps_q <= cfg_data;
		end
	end

	// stage 1: capture coefficients
	logic          v_s1;
	logic [W-1:0]  a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= s_axis_tdata[W-1:0];
			b_s1 <= s_axis_tdata[2*W-1:W];
			c_s1 <= s_axis_tdata[3*W-1:2*W];
		end
	end

	// stage 2: magnitudes, near-zero tests, classification
	logic          v_s2;
	fr_t           fr_s2;
	logic          sdiff_s2;
	fr_t           fr_c2;
	logic [W-1:0]  eps_w;
	logic          za, zb, zc, b_nz, c_nz, a_ng, b_ng, c_ng;

	assign eps_w = W'(eps_q);

	always_comb begin
		a_ng       = a_s1[W-1];
		b_ng       = b_s1[W-1];
		c_ng       = c_s1[W-1];
		b_nz       = b_s1 != '0;
		c_nz       = c_s1 != '0;
		fr_c2.amag = a_ng ? -a_s1 : a_s1;
		fr_c2.bmag = b_ng ? -b_s1 : b_s1;
		fr_c2.cmag = c_ng ? -c_s1 : c_s1;
		fr_c2.b    = b_s1;
		fr_c2.a_neg = a_ng;
		za = fr_c2.amag < eps_w;
		zb = fr_c2.bmag < eps_w;
		zc = fr_c2.cmag < eps_w;
		fr_c2.mode = MD_FIXED;
		fr_c2.cnt  = CNT_NONE;
		fr_c2.neg1 = 1'b0;
		if (za) begin
			if (zb) begin
				fr_c2.cnt = zc ? CNT_INF : CNT_NONE;
			end else if (zc) begin
				fr_c2.cnt = CNT_ONE;
			end else begin
				fr_c2.mode = MD_LIN;
				fr_c2.cnt  = CNT_ONE;
				fr_c2.neg1 = c_nz && (c_ng == b_ng);
			end
		end else if (zb) begin
			if (zc) begin
				fr_c2.cnt = CNT_ONE;
			end else if (c_nz && (c_ng != a_ng)) begin
				fr_c2.mode = MD_SQRT;
				fr_c2.cnt  = CNT_TWO;
			end
		end else if (zc) begin
			fr_c2.mode = MD_ZC;
			fr_c2.cnt  = CNT_TWO;
			fr_c2.neg1 = b_nz && (b_ng == a_ng);
		end else begin
			fr_c2.mode = MD_GEN;
			fr_c2.cnt  = CNT_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s2    <= fr_c2;
			sdiff_s2 <= a_s1[W-1] != c_s1[W-1];
		end
	end

	// stage 3: b*b and a*c
	logic          v_s3;
	fr_t           fr_s3;
	logic          sdiff_s3;
	logic [PW-1:0] bb_s3, ac_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s3    <= fr_s2;
			sdiff_s3 <= sdiff_s2;
			bb_s3    <= fr_s2.bmag * fr_s2.bmag;
			ac_s3    <= fr_s2.amag * fr_s2.cmag;
		end
	end

	// stage 4: discriminant and the real-root test
	logic          v_s4;
	d0_t           d0_s4;
	d0_t           d0_c4;
	logic [PW+1:0] bbx, four, dsum;

	always_comb begin
		bbx   = (PW + 2)'(bb_s3);
		four  = {ac_s3, 2'b00};
		d0_c4.f = fr_s3;
		if (sdiff_s3) begin
			dsum = bbx + four;
		end else begin
			dsum = bbx - four;
			if (bbx < four && fr_s3.mode == MD_GEN) begin
				d0_c4.f.mode = MD_FIXED;
				d0_c4.f.cnt  = CNT_NONE;
			end
		end
		d0_c4.d = dsum[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d0_s4 <= d0_c4;
		end
	end

	// zero-b ratio |c| * 2^(2F) / |a|, floored
	logic          v0;
	logic [N0-1:0] q0;
	d0_t           d0o;

	qrs_div #(
		.NB (N0),
		.DB (W),
		.SB ($bits(d0_t))
	) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.num       ({d0_s4.f.cmag, {(2 * F){1'b0}}}),
		.den       (d0_s4.f.amag),
		.side_in   (d0_s4),
		.out_valid (v0),
		.quo       (q0),
		.rem       (),
		.den_out   (),
		.side_out  (d0o)
	);

	// square root, one result bit per stage
	logic [SXE-1:0] sq_x0;
	logic [SXE-1:0] sx_s    [SR];
	logic [RW-1:0]  srem_s  [SR];
	logic [SR-1:0]  sroot_s [SR];
	fr_t            sfr_s   [SR];
	logic           sv_s    [SR];

	assign sq_x0 = (d0o.f.mode == MD_SQRT) ? SXE'(q0) : SXE'(d0o.d);

	for (genvar i = 0; i < SR; i++) begin : g_sqrt
		logic [SXE-1:0] x_in;
		logic [RW-1:0]  r_in;
		logic [SR-1:0]  t_in;
		fr_t            f_in;
		logic           v_in;
		logic [RW+1:0]  remc, trial, diff;
		logic           ge;

		if (i == 0) begin : g_first
			assign x_in = sq_x0;
			assign r_in = '0;
			assign t_in = '0;
			assign f_in = d0o.f;
			assign v_in = v0;
		end else begin : g_next
			assign x_in = sx_s[i-1];
			assign r_in = srem_s[i-1];
			assign t_in = sroot_s[i-1];
			assign f_in = sfr_s[i-1];
			assign v_in = sv_s[i-1];
		end

		// append the next bit pair and try 4*root+1
		assign remc  = {r_in, x_in[SXE-1 -: 2]};
		assign trial = (RW + 2)'({t_in, 2'b01});
		assign diff  = remc - trial;
		assign ge    = remc >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[i] <= 1'b0;
			end else if (en) begin
				sv_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sx_s[i]    <= {x_in[SXE-3:0], 2'b00};
				srem_s[i]  <= ge ? diff[RW-1:0] : remc[RW-1:0];
				sroot_s[i] <= {t_in[SR-2:0], ge};
				sfr_s[i]   <= f_in;
			end
		end
	end

	// stage 5: round the root to nearest
	logic          v_s5;
	logic [SR:0]   s_s5;
	fr_t           fr_s5;
	logic          sq_up;

	assign sq_up = srem_s[SR-1] > RW'(sroot_s[SR-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= sv_s[SR-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5  <= (SR + 1)'(sroot_s[SR-1]) + (SR + 1)'(sq_up);
			fr_s5 <= sfr_s[SR-1];
		end
	end

	// stage 6: numerators -b -+ s and divider operand selection
	logic                 v_s6;
	logic [N1-1:0]        num1_s6, num2_s6;
	logic [DB1-1:0]       den1_s6, den2_s6;
	bk_t                  bk_s6;
	logic                 neg2_s6;
	logic signed [NW-1:0] bx, sx, n1, n2;
	logic [NM-1:0]        n1mag, n2mag;
	logic [N1-1:0]        num1_c;
	logic [DB1-1:0]       den1_c, den2_a;
	bk_t                  bk_c6;
	logic                 neg2_c;

	always_comb begin
		bx     = {{(NW - W){fr_s5.b[W-1]}}, fr_s5.b};
		sx     = {{(NW - SR - 1){1'b0}}, s_s5};
		n1     = -bx - sx;
		n2     = -bx + sx;
		n1mag  = n1[NW-1] ? NM'(-n1) : NM'(n1);
		n2mag  = n2[NW-1] ? NM'(-n2) : NM'(n2);
		den2_a = {fr_s5.amag, 1'b0};
		neg2_c = (n2 != '0) && (n2[NW-1] != fr_s5.a_neg);
		bk_c6.mode = fr_s5.mode;
		bk_c6.cnt  = fr_s5.cnt;
		bk_c6.s    = s_s5;
		unique case (fr_s5.mode)
			MD_LIN: begin
				num1_c     = N1'({fr_s5.cmag, {F{1'b0}}});
				den1_c     = DB1'(fr_s5.bmag);
				bk_c6.neg1 = fr_s5.neg1;
			end
			MD_ZC: begin
				num1_c     = N1'({fr_s5.bmag, {F{1'b0}}});
				den1_c     = DB1'(fr_s5.amag);
				bk_c6.neg1 = fr_s5.neg1;
			end
			default: begin
				num1_c     = {n1mag, {F{1'b0}}};
				den1_c     = den2_a;
				bk_c6.neg1 = (n1 != '0) && (n1[NW-1] != fr_s5.a_neg);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s6 <= num1_c;
			num2_s6 <= {n2mag, {F{1'b0}}};
			den1_s6 <= den1_c;
			den2_s6 <= den2_a;
			bk_s6   <= bk_c6;
			neg2_s6 <= neg2_c;
		end
	end

	// root dividers
	logic           v1;
	logic [N1-1:0]  q1, q2;
	logic [DB1-1:0] r1, r2, dd1, dd2;
	bk_t            bk1;
	logic           neg2o;

	qrs_div #(
		.NB (N1),
		.DB (DB1),
		.SB ($bits(bk_t))
	) u_div_root1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (num1_s6),
		.den       (den1_s6),
		.side_in   (bk_s6),
		.out_valid (v1),
		.quo       (q1),
		.rem       (r1),
		.den_out   (dd1),
		.side_out  (bk1)
	);

	qrs_div #(
		.NB (N1),
		.DB (DB1),
		.SB (1)
	) u_div_root2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (num2_s6),
		.den       (den2_s6),
		.side_in   (neg2_s6),
		.out_valid (),
		.quo       (q2),
		.rem       (r2),
		.den_out   (dd2),
		.side_out  (neg2o)
	);

	// stage 7: round half away from zero and apply the sign
	logic                 v_s7;
	logic signed [XW-1:0] x1_s7, x2_s7;
	bk_t                  bk_s7;
	logic [N1:0]          mag1, mag2;
	logic signed [XW-1:0] m1x, m2x;

	always_comb begin
		mag1 = (dd1 == '0) ? '1 :
			(N1 + 1)'(q1) + (N1 + 1)'({r1, 1'b0} >= {1'b0, dd1});
		mag2 = (dd2 == '0) ? '1 :
			(N1 + 1)'(q2) + (N1 + 1)'({r2, 1'b0} >= {1'b0, dd2});
		m1x  = XW'(mag1);
		m2x  = XW'(mag2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s7 <= bk1.neg1 ? -m1x : m1x;
			x2_s7 <= neg2o ? -m2x : m2x;
			bk_s7 <= bk1;
		end
	end

	// stage 8: equal-root test, ordering, clamp, output register
	logic                 v_s8;
	logic [1:0]           cnt_s8;
	logic [W-1:0]         lo_s8, hi_s8;
	logic                 ovf_s8;
	logic signed [XW-1:0] sp, lo_v, hi_v;
	logic signed [XW:0]   dx;
	logic [XW:0]          dmag;
	logic                 close;
	logic [1:0]           cnt_c;
	logic [W:0]           lo_sat, hi_sat;

	always_comb begin
		sp    = $signed({{(XW - SR - 1){1'b0}}, bk_s7.s});
		dx    = {x1_s7[XW-1], x1_s7} - {x2_s7[XW-1], x2_s7};
		dmag  = dx[XW] ? -dx : dx;
		close = dmag < (XW + 1)'(eps_q);
		cnt_c = bk_s7.cnt;
		lo_v  = '0;
		hi_v  = '0;
		unique case (bk_s7.mode)
			MD_LIN: begin
				lo_v = x1_s7;
			end
			MD_SQRT: begin
				lo_v = -sp;
				hi_v = sp;
			end
			MD_ZC: begin
				lo_v = x1_s7[XW-1] ? x1_s7 : '0;
				hi_v = x1_s7[XW-1] ? '0 : x1_s7;
			end
			MD_GEN: begin
				if (close) begin
					cnt_c = CNT_ONE;
					lo_v  = x1_s7;
				end else begin
					lo_v = (x1_s7 < x2_s7) ? x1_s7 : x2_s7;
					hi_v = (x1_s7 < x2_s7) ? x2_s7 : x1_s7;
				end
			end
			default: begin
				lo_v = '0;
				hi_v = '0;
			end
		endcase
		lo_sat = sat_w(lo_v);
		hi_sat = sat_w(hi_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s8 <= cnt_c;
			lo_s8  <= lo_sat[W-1:0];
			hi_s8  <= hi_sat[W-1:0];
			ovf_s8 <= lo_sat[W] | hi_sat[W];
		end
	end

	assign m_axis_tvalid = v_s8;
	assign m_axis_tdata  = TDO'({hi_s8, lo_s8});
	assign m_axis_tuser  = {ovf_s8, cnt_s8};

	// no roots or infinitely many: both root fields and the flag are clear
	a_empty_roots: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && (cnt_s8 == CNT_NONE || cnt_s8 == CNT_INF)
		|-> lo_s8 == '0 && hi_s8 == '0 && !ovf_s8)
		else $error("root fields not clear for a rootless result");

	// a single root leaves the upper field clear
	a_single_root: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && cnt_s8 == CNT_ONE |-> hi_s8 == '0)
		else $error("upper root set for a single-root result");

	// two roots come out in ascending order
	a_root_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && cnt_s8 == CNT_TWO |-> $signed(lo_s8) <= $signed(hi_s8))
		else $error("roots out of order");

	// an input transfer always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted equation lost at the first stage");

endmodule
